FILE: src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define XTD_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define XTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/xtd_pkg.sv
// Package for the XML text entity decoder: parser state, result type, codes
// and the UTF-8 and entity spelling helpers. No dependencies.
package xtd_pkg;

	localparam int CpW = 21;
	localparam logic [CpW-1:0] MaxCp = 21'h10FFFF;

	typedef enum logic [10:0] {
		MODE_PLAIN     = 11'b000_0000_0001,
		MODE_AMP       = 11'b000_0000_0010,
		MODE_A         = 11'b000_0000_0100,
		MODE_WORD_QUOT = 11'b000_0000_1000,
		MODE_WORD_LT   = 11'b000_0001_0000,
		MODE_WORD_GT   = 11'b000_0010_0000,
		MODE_WORD_AMP  = 11'b000_0100_0000,
		MODE_WORD_APOS = 11'b000_1000_0000,
		MODE_HASH      = 11'b001_0000_0000,
		MODE_NUM       = 11'b010_0000_0000,
		MODE_SEMI      = 11'b100_0000_0000
	} mode_t;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
	localparam logic [2:0] ERR_MISMATCH = 3'd2;
	localparam logic [2:0] ERR_NOSEMI   = 3'd3;
	localparam logic [2:0] ERR_INVALID  = 3'd4;

	localparam logic [2:0] WORD_QUOT = 3'd0;
	localparam logic [2:0] WORD_LT   = 3'd1;
	localparam logic [2:0] WORD_GT   = 3'd2;
	localparam logic [2:0] WORD_AMP  = 3'd3;
	localparam logic [2:0] WORD_APOS = 3'd4;

	typedef struct packed {
		mode_t          mode;
		logic [2:0]     match_pos;
		logic [CpW-1:0] value;
		logic           overflow;
		logic           hex;
	} state_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [31:0] bytes;
		logic [2:0]  count;
		logic [2:0]  err;
	} res_t;

	function automatic logic is_ch(logic [CpW-1:0] c, logic [7:0] ch);
		return c == {{(CpW-8){1'b0}}, ch};
	endfunction

	function automatic logic cp_valid(logic [CpW-1:0] c);
		return (c != '0 && c < 21'h00D800) || (c >= 21'h00E000 && c <= MaxCp);
	endfunction

	// Result for one character: UTF-8 bytes, or an invalid code point error.
	function automatic res_t emit_char(logic [CpW-1:0] c);
		res_t r;
		r = '0;
		r.valid = 1'b1;
		if (!cp_valid(c)) begin
			r.kind = KIND_ERR;
			r.err  = ERR_INVALID;
		end else if (c < 21'h000080) begin
			r.kind  = KIND_DATA;
			r.bytes = {25'b0, c[6:0]};
			r.count = 3'd1;
		end else if (c < 21'h000800) begin
			r.kind  = KIND_DATA;
			r.bytes = {16'b0, 2'b10, c[5:0], 3'b110, c[10:6]};
			r.count = 3'd2;
		end else if (c < 21'h010000) begin
			r.kind  = KIND_DATA;
			r.bytes = {8'b0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
			r.count = 3'd3;
		end else begin
			r.kind  = KIND_DATA;
			r.bytes = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
			r.count = 3'd4;
		end
		return r;
	endfunction

	function automatic res_t fail(logic [2:0] err);
		res_t r;
		r = '0;
		r.valid = 1'b1;
		r.kind  = KIND_ERR;
		r.err   = err;
		return r;
	endfunction

	// Expected letter of a named entity at a position after its first letter.
	function automatic logic [7:0] word_letter(logic [2:0] w, logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case ({w, pos})
			{WORD_QUOT, 3'd1}: ch = "u";
			{WORD_QUOT, 3'd2}: ch = "o";
			{WORD_QUOT, 3'd3}: ch = "t";
			{WORD_LT, 3'd1}:   ch = "t";
			{WORD_GT, 3'd1}:   ch = "t";
			{WORD_AMP, 3'd1}:  ch = "p";
			{WORD_APOS, 3'd1}: ch = "o";
			{WORD_APOS, 3'd2}: ch = "s";
			default:           ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [2:0] word_len(logic [2:0] w);
		logic [2:0] n;
		case (w)
			WORD_QUOT: n = 3'd4;
			WORD_APOS: n = 3'd3;
			default:   n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] word_char(logic [2:0] w);
		logic [7:0] ch;
		case (w)
			WORD_QUOT: ch = 8'h22;
			WORD_LT:   ch = 8'h3C;
			WORD_GT:   ch = 8'h3E;
			WORD_AMP:  ch = 8'h26;
			default:   ch = 8'h27;
		endcase
		return ch;
	endfunction

endpackage

FILE: src/xml_text_entity_decoder.sv
// Top level of the XML text entity decoder: input register, parser state and
// result register around xtd_core. Depends on xtd_pkg and assert_macros.svh.
//
//   Channel   Handshake            Payload
//   in        in_valid/in_ready    code_point, delimiter_select
//   out       out_valid/out_ready  kind, utf8_bytes, byte_count, error_code
//
// One code point per cycle while the result register is not stalled; a result
// passes from the input register into the result register and is offered there.
// Requests that open or continue an entity update the parser state and give no result.
// Reset clears the parser state to plain text and empties both registers.
// A stalled result holds the input register, which then stalls the input.
`include "assert_macros.svh"

module xml_text_entity_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [20:0] code_point,
	input  logic [1:0]  delimiter_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] utf8_bytes,
	output logic [2:0]  byte_count,
	output logic [2:0]  error_code
);
	import xtd_pkg::*;

	logic           valid_s1;
	logic [CpW-1:0] cp_s1;
	logic [1:0]     sel_s1;
	state_t         state_q;
	state_t         state_nxt;
	res_t           res;
	logic           adv;
	logic           out_valid_q;
	logic [1:0]     kind_q;
	logic [31:0]    bytes_q;
	logic [2:0]     count_q;
	logic [2:0]     err_q;
	logic           data_ok;
	logic           nondata_ok;
	logic           err_ok;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cp_s1  <= code_point;
			sel_s1 <= delimiter_select;
		end
	end

	xtd_core u_core (
		.st  (state_q),
		.cp  (cp_s1),
		.sel (sel_s1),
		.nxt (state_nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_PLAIN, match_pos: 3'd0, value: '0,
				overflow: 1'b0, hex: 1'b0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			kind_q  <= res.kind;
			bytes_q <= res.bytes;
			count_q <= res.count;
			err_q   <= res.err;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign utf8_bytes = bytes_q;
	assign byte_count = count_q;
	assign error_code = err_q;

	assign data_ok    = byte_count != 3'd0 && byte_count <= 3'd4 && error_code == ERR_NONE;
	assign nondata_ok = utf8_bytes == '0 && byte_count == 3'd0;
	assign err_ok     = error_code != ERR_NONE && error_code <= ERR_INVALID;

	`XTD_ASSERT(a_data_shape, !out_valid || kind != KIND_DATA || data_ok, "bad data result")
	`XTD_ASSERT(a_nondata_empty, !out_valid || kind == KIND_DATA || nondata_ok, "result has bytes")
	`XTD_ASSERT(a_err_code, !out_valid || kind != KIND_ERR || err_ok, "error result without a code")
	`XTD_ASSERT_NEXT(a_result_resets, adv && res.valid, state_q.mode == MODE_PLAIN, "no plain text")

endmodule

FILE: src/xtd_core.sv
// Next-state and result logic of the entity decoder for one code point.
// Purely combinational; depends on xtd_pkg.
module xtd_core (
	input  xtd_pkg::state_t        st,
	input  logic [20:0]            cp,
	input  logic [1:0]             sel,
	output xtd_pkg::state_t        nxt,
	output xtd_pkg::res_t          res
);
	import xtd_pkg::*;

	logic [7:0]     delim;
	logic [2:0]     word;
	logic           is_word;
	logic           num_hex;
	logic [CpW-1:0] num_val;
	logic           num_ovf;
	logic           is09;
	logic           letter;
	logic           digit_ok;
	logic [3:0]     digit;
	logic [24:0]    prod;
	logic [2:0]     pos_inc;

	always_comb begin
		case (sel)
			2'd1:    delim = 8'h22;
			2'd2:    delim = 8'h27;
			default: delim = 8'h3C;
		endcase
	end

	always_comb begin
		is_word = 1'b1;
		case (st.mode)
			MODE_WORD_QUOT: word = WORD_QUOT;
			MODE_WORD_LT:   word = WORD_LT;
			MODE_WORD_GT:   word = WORD_GT;
			MODE_WORD_AMP:  word = WORD_AMP;
			MODE_WORD_APOS: word = WORD_APOS;
			default: begin
				word    = WORD_QUOT;
				is_word = 1'b0;
			end
		endcase
	end

	// The first digit of a decimal reference arrives in the hash state with a fresh value.
	assign num_hex = (st.mode == MODE_NUM) ? st.hex : 1'b0;
	assign num_val = (st.mode == MODE_NUM) ? st.value : '0;
	assign num_ovf = (st.mode == MODE_NUM) ? st.overflow : 1'b0;

	assign is09     = cp >= 21'h30 && cp <= 21'h39;
	assign letter   = (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
	assign digit_ok = is09 || (num_hex && letter && cp[4:0] <= 5'd6);
	assign digit    = is09 ? cp[3:0] : cp[3:0] + 4'd9;
	assign prod     = num_hex ? ({num_val, 4'b0} + {21'b0, digit})
		: ({1'b0, num_val, 3'b0} + {3'b0, num_val, 1'b0} + {21'b0, digit});
	assign pos_inc  = st.match_pos + 3'd1;

	always_comb begin
		nxt = st;
		res = '0;
		case (st.mode)
			MODE_PLAIN: begin
				if (is_ch(cp, delim) || is_ch(cp, 8'h3C) || cp == '0) begin
					res.valid = 1'b1;
					res.kind  = KIND_END;
				end else if (is_ch(cp, 8'h26)) begin
					nxt.mode = MODE_AMP;
				end else begin
					res = emit_char(cp);
				end
			end
			MODE_AMP: begin
				nxt.match_pos = 3'd1;
				if (is_ch(cp, "q")) begin
					nxt.mode = MODE_WORD_QUOT;
				end else if (is_ch(cp, "l")) begin
					nxt.mode = MODE_WORD_LT;
				end else if (is_ch(cp, "g")) begin
					nxt.mode = MODE_WORD_GT;
				end else if (is_ch(cp, "a")) begin
					nxt.mode      = MODE_A;
					nxt.match_pos = st.match_pos;
				end else if (is_ch(cp, "#")) begin
					nxt.mode      = MODE_HASH;
					nxt.match_pos = st.match_pos;
				end else begin
					nxt.match_pos = st.match_pos;
					res           = fail(ERR_UNKNOWN);
				end
			end
			MODE_A: begin
				if (is_ch(cp, "m")) begin
					nxt.mode      = MODE_WORD_AMP;
					nxt.match_pos = 3'd1;
				end else if (is_ch(cp, "p")) begin
					nxt.mode      = MODE_WORD_APOS;
					nxt.match_pos = 3'd1;
				end else begin
					res = fail(ERR_MISMATCH);
				end
			end
			MODE_WORD_QUOT, MODE_WORD_LT, MODE_WORD_GT, MODE_WORD_AMP, MODE_WORD_APOS: begin
				if (!is_word || st.match_pos >= word_len(word)
						|| !is_ch(cp, word_letter(word, st.match_pos))) begin
					res = fail(ERR_MISMATCH);
				end else begin
					nxt.match_pos = pos_inc;
					if (pos_inc == word_len(word)) begin
						nxt.value = {13'b0, word_char(word)};
						nxt.mode  = MODE_SEMI;
					end
				end
			end
			MODE_HASH, MODE_NUM: begin
				if (st.mode == MODE_HASH && (is_ch(cp, "x") || is_ch(cp, "X"))) begin
					nxt.mode     = MODE_NUM;
					nxt.hex      = 1'b1;
					nxt.value    = '0;
					nxt.overflow = 1'b0;
				end else begin
					nxt.mode     = MODE_NUM;
					nxt.hex      = num_hex;
					nxt.value    = num_val;
					nxt.overflow = num_ovf;
					if (digit_ok) begin
						if (prod > {4'b0, MaxCp}) begin
							nxt.overflow = 1'b1;
						end else begin
							nxt.value = prod[CpW-1:0];
						end
					end else if (!is_ch(cp, ";")) begin
						res = fail(ERR_NOSEMI);
					end else if (num_ovf) begin
						res = fail(ERR_INVALID);
					end else begin
						res = emit_char(num_val);
					end
				end
			end
			MODE_SEMI: begin
				if (!is_ch(cp, ";")) begin
					res = fail(ERR_NOSEMI);
				end else begin
					res = emit_char(st.value);
				end
			end
			default: begin
				nxt.mode = MODE_PLAIN;
			end
		endcase
		if (res.valid) begin
			nxt.mode = MODE_PLAIN;
		end
	end

endmodule
